/* src/dmd_pkg.sv */
// ----------------------------------------------------------------------------
// dmd_pkg
// Shared types, widths and helpers for the distance matrix distortion block.
// ----------------------------------------------------------------------------
package dmd_pkg;

	// matrix side and index widths
	localparam int MAX_POINTS = 32;
	localparam int ROW_W      = 5;
	localparam int CNT_W      = 6;

	// arithmetic widths
	localparam int DIST_W     = 16;
	localparam int SQ_W       = 2 * DIST_W;
	localparam int SUM_W      = SQ_W + ROW_W;
	localparam int DEN_W      = SQ_W + ROW_W;
	localparam int QUO_W      = 24;
	localparam int NUM_W      = 54;
	localparam int OUT_W      = 24;
	localparam int VAL_W      = OUT_W + 2;
	localparam int TOT_W      = OUT_W + ROW_W;
	localparam int MEAN_W     = TOT_W + 2;
	localparam int DIV_CNT_W  = 5;

	localparam logic [SQ_W-1:0] ONE_Q16 = SQ_W'(65536);
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};

	// one input item
	typedef struct packed {
		logic [DIST_W-1:0] high_dist;
		logic [DIST_W-1:0] low_dist;
	} dist_item_t;

	// one result item
	typedef struct packed {
		logic                    is_overall;
		logic [ROW_W-1:0]        row_index;
		logic signed [OUT_W-1:0] distortion;
		logic                    last_result;
	} dist_result_t;

	// control of the result sequencer
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_DRAIN,
		ST_SETUP,
		ST_READ,
		ST_CHECK,
		ST_DIV,
		ST_EMIT,
		ST_MEAN
	} dmd_state_t;

	// saturate a widened value to the output range
	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [VAL_W-1:0] v);
		logic signed [OUT_W-1:0] r;
		if (v < VAL_W'(OUT_MIN)) begin
			r = OUT_MIN;
		end else if (v > VAL_W'(OUT_MAX)) begin
			r = OUT_MAX;
		end else begin
			r = v[OUT_W-1:0];
		end
		return r;
	endfunction

endpackage

/* src/dmd_sum_ram.sv */
// ----------------------------------------------------------------------------
// dmd_sum_ram
// Row sum store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dmd_sum_ram import dmd_pkg::*; (
	input  logic             clk,
	input  logic             we,
	input  logic [ROW_W-1:0] waddr,
	input  logic [SUM_W-1:0] wdata,
	input  logic [ROW_W-1:0] raddr,
	output logic [SUM_W-1:0] rdata
);

	logic [SUM_W-1:0] mem [MAX_POINTS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* src/dmd_accum.sv */
// ----------------------------------------------------------------------------
// dmd_accum
// Element pipeline: absolute difference, square, row sum and running maximum.
// ----------------------------------------------------------------------------
module dmd_accum import dmd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  dist_item_t       item,
	input  logic [CNT_W-1:0] side,
	input  logic             run_clear,
	output logic             last_pos,
	output logic             wr_en,
	output logic [ROW_W-1:0] wr_addr,
	output logic [SUM_W-1:0] wr_data,
	output logic [SQ_W-1:0]  max_sq,
	output logic             done
);

	logic [ROW_W-1:0]  row_q, col_q;
	logic              col_last, row_last;
	logic              valid_s1, valid_s2;
	logic [DIST_W-1:0] diff_s1;
	logic              upper_s1, upper_s2;
	logic              rend_s1, rend_s2;
	logic              last_s1, last_s2;
	logic [ROW_W-1:0]  row_s1, row_s2;
	logic [SQ_W-1:0]   sq_s2;
	logic [SUM_W-1:0]  acc_q, sum;
	logic [SQ_W-1:0]   max_q;
	logic              done_q;

	// position of the next element
	assign col_last = (CNT_W'(col_q) + CNT_W'(1)) == side;
	assign row_last = (CNT_W'(row_q) + CNT_W'(1)) == side;
	assign last_pos = col_last & row_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (run_clear) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + ROW_W'(1);
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			done_q   <= valid_s2 & last_s2;
		end
	end

	// stage 1: absolute difference
	always_ff @(posedge clk) begin
		diff_s1  <= (item.low_dist >= item.high_dist) ? item.low_dist - item.high_dist
		                                              : item.high_dist - item.low_dist;
		upper_s1 <= col_q > row_q;
		rend_s1  <= col_last;
		last_s1  <= last_pos;
		row_s1   <= row_q;
	end

	// stage 2: square
	always_ff @(posedge clk) begin
		sq_s2    <= SQ_W'(diff_s1) * SQ_W'(diff_s1);
		upper_s2 <= upper_s1;
		rend_s2  <= rend_s1;
		last_s2  <= last_s1;
		row_s2   <= row_s1;
	end

	// row accumulation, written to the store at the end of each row
	assign sum     = acc_q + SUM_W'(sq_s2);
	assign wr_en   = valid_s2 & rend_s2;
	assign wr_addr = row_s2;
	assign wr_data = sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			max_q <= '0;
		end else if (run_clear) begin
			acc_q <= '0;
			max_q <= '0;
		end else if (valid_s2) begin
			acc_q <= rend_s2 ? '0 : sum;
			if (upper_s2 && sq_s2 > max_q) begin
				max_q <= sq_s2;
			end
		end
	end

	assign max_sq = max_q;
	assign done   = done_q;

endmodule

/* src/dmd_divider.sv */
// ----------------------------------------------------------------------------
// dmd_divider
// Restoring divider, one quotient bit per cycle. The upper dividend bits
// must already be below the divisor, so the quotient fits QUO_W bits.
// ----------------------------------------------------------------------------
module dmd_divider import dmd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [QUO_W-1:0] quotient
);

	logic [DEN_W-1:0]     rem_q;
	logic [QUO_W-1:0]     low_q;
	logic [DEN_W-1:0]     div_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q, done_q;
	logic [DEN_W:0]       trial, diff;

	// one trial subtraction
	assign trial = {rem_q, low_q[QUO_W-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(dividend[NUM_W-1:QUO_W]);
			low_q <= dividend[QUO_W-1:0];
			div_q <= divisor;
		end else if (busy_q) begin
			if (!diff[DEN_W]) begin
				rem_q <= diff[DEN_W-1:0];
				low_q <= {low_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DEN_W-1:0];
				low_q <= {low_q[QUO_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = low_q;

endmodule

/* src/distance_matrix_distortion.sv */
// ----------------------------------------------------------------------------
// distance_matrix_distortion
// Distortion between two n-by-n distance matrices, one row value each and
// an overall mean.
// ----------------------------------------------------------------------------
// Usage
//   item channel: pairs of Q8.8 distances, row-major, one item per cycle
//   while a matrix is loading. After the last element of the matrix the
//   channel holds ready low until the overall result enters the output register.
//   result channel: n row results (row_index 0..n-1) and then the overall
//   mean with is_overall and last_result set. Results sit in an output
//   register; a stalled receiver simply holds the sequencer.
//   cfg_we/cfg_wdata: writes the point count n (0 acts as 1, above 32 as 32)
//   and restarts the current matrix. Write only while idle.
// Timing
//   Loading: one item per cycle. Tail after the last item: pipeline drain and
//   setup, then per row a row sum store read, range check, divider steps (one
//   per quotient bit, plus a done step) and output, with the divider skipped
//   when the row value saturates, then a divider pass for the mean.
// Reset
//   n returns to 32, positions and accumulators are cleared; the row sum
//   store needs no clearing since each row is written before it is read.
// ----------------------------------------------------------------------------
module distance_matrix_distortion import dmd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_ready,
	input  dist_item_t   item,
	output logic         result_valid,
	input  logic         result_ready,
	output dist_result_t result,
	input  logic         cfg_we,
	input  logic [5:0]   cfg_wdata
);

	dmd_state_t state_q, state_d;

	logic [CNT_W-1:0]  cfg_q, side;
	logic              run_clear, accept, last_pos;
	logic              wr_en, acc_done;
	logic [ROW_W-1:0]  wr_addr, row_idx_q;
	logic [SUM_W-1:0]  wr_data, rd_data;
	logic [SQ_W-1:0]   max_sq, mx_sel;
	logic [DEN_W-1:0]  den_q, divisor;
	logic [NUM_W-1:0]  row_num, mean_num, dividend;
	logic              row_ovf;
	logic              mean_q, neg_q;
	logic              div_start, div_done;
	logic [QUO_W-1:0]  quotient;
	logic signed [VAL_W-1:0]  qx, val;
	logic signed [OUT_W-1:0]  res_q;
	logic signed [TOT_W-1:0]  total_q;
	logic signed [MEAN_W-1:0] mean_a, mean_mag;
	logic              can_load, emit_load, row_final;
	logic              result_valid_q;
	dist_result_t      result_q;

	// point count register and effective side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CNT_W'(MAX_POINTS);
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (cfg_q == '0) begin
			side = CNT_W'(1);
		end else if (cfg_q > CNT_W'(MAX_POINTS)) begin
			side = CNT_W'(MAX_POINTS);
		end else begin
			side = cfg_q;
		end
	end

	assign accept = item_valid & item_ready;

	dmd_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.side      (side),
		.run_clear (run_clear),
		.last_pos  (last_pos),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.max_sq    (max_sq),
		.done      (acc_done)
	);

	dmd_sum_ram u_sum_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (row_idx_q),
		.rdata (rd_data)
	);

	// dividend for a row value: rowsum * 2^16 + den / 2
	assign row_num = NUM_W'({rd_data, 16'h0000}) + NUM_W'(den_q >> 1);
	assign row_ovf = DEN_W'(row_num[NUM_W-1:QUO_W]) >= den_q;

	// dividend for the mean: floor((2 * total + n) / (2 * n))
	assign mean_a   = {total_q[TOT_W-1], total_q, 1'b0} + MEAN_W'(side);
	assign mean_mag = mean_a[MEAN_W-1] ? (-mean_a + MEAN_W'({side, 1'b0}) - MEAN_W'(1))
	                                   : mean_a;
	assign mean_num = NUM_W'(unsigned'(mean_mag));

	assign dividend = (state_q == ST_MEAN) ? mean_num : row_num;
	assign divisor  = (state_q == ST_MEAN) ? DEN_W'({side, 1'b0}) : den_q;

	dmd_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	// value from the quotient
	assign qx  = $signed({2'b00, quotient});
	assign val = mean_q ? (neg_q ? -qx : qx) : (VAL_W'(65536) - qx);

	assign mx_sel    = (max_sq == '0) ? ONE_Q16 : max_sq;
	assign can_load  = ~result_valid_q | result_ready;
	assign row_final = (CNT_W'(row_idx_q) + CNT_W'(1)) == side;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:  if (item_valid && last_pos) state_d = ST_DRAIN;
			ST_DRAIN: if (acc_done) state_d = ST_SETUP;
			ST_SETUP: state_d = ST_READ;
			ST_READ:  state_d = ST_CHECK;
			ST_CHECK: state_d = row_ovf ? ST_EMIT : ST_DIV;
			ST_DIV:   if (div_done) state_d = ST_EMIT;
			ST_EMIT: begin
				if (can_load) begin
					if (mean_q) begin
						state_d = ST_LOAD;
					end else if (row_final) begin
						state_d = ST_MEAN;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_MEAN:  state_d = ST_DIV;
			default:  state_d = ST_LOAD;
		endcase
	end

	// sequencer outputs
	always_comb begin
		item_ready = (state_q == ST_LOAD) & ~cfg_we;
		run_clear  = cfg_we | (state_q == ST_SETUP);
		div_start  = ((state_q == ST_CHECK) & ~row_ovf) | (state_q == ST_MEAN);
		emit_load  = (state_q == ST_EMIT) & can_load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else if (cfg_we) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// tail datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_idx_q <= '0;
			mean_q    <= 1'b0;
			total_q   <= '0;
		end else begin
			if (state_q == ST_SETUP) begin
				row_idx_q <= '0;
				mean_q    <= 1'b0;
				total_q   <= '0;
			end else if (state_q == ST_MEAN) begin
				mean_q <= 1'b1;
			end else if (emit_load && !mean_q) begin
				total_q <= total_q + TOT_W'(res_q);
				if (!row_final) begin
					row_idx_q <= row_idx_q + ROW_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP) begin
			den_q <= DEN_W'(mx_sel) * DEN_W'(side);
		end
		if (state_q == ST_MEAN) begin
			neg_q <= mean_a[MEAN_W-1];
		end
		if (state_q == ST_CHECK && row_ovf) begin
			res_q <= OUT_MIN;
		end else if (state_q == ST_DIV && div_done) begin
			res_q <= sat_out(val);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			result_q.is_overall  <= mean_q;
			result_q.row_index   <= mean_q ? '0 : row_idx_q;
			result_q.distortion  <= res_q;
			result_q.last_result <= mean_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
